// ===== design/msat_pkg.sv =====
// shared types, constants and helpers for the segment decode and tlb translate block
package msat_pkg;

   // tlb geometry
   localparam int TLB_DEPTH   = 64;
   localparam int CELL_IDX_W  = $clog2(TLB_DEPTH);

   // fixed field widths
   localparam int ADDR_W      = 32;
   localparam int ENTRY_IDX_W = 6;
   localparam int STATUS_W    = 2;
   localparam int PFN_W       = 20;
   localparam int VPN2_W      = 19;
   localparam int MASK_W      = 12;

   // action codes
   localparam logic ACTION_TRANSLATE = 1'b0;
   localparam logic ACTION_WRITE     = 1'b1;

   // result status codes
   localparam logic [STATUS_W-1:0] STATUS_DIRECT  = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_HIT     = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_MISS    = 2'd2;
   localparam logic [STATUS_W-1:0] STATUS_WRITTEN = 2'd3;

   // segment codes taken from address bits 31..29
   localparam logic [2:0] SEG_KSEG0 = 3'b100;
   localparam logic [2:0] SEG_KSEG1 = 3'b101;
   localparam logic [2:0] SEG_KSSEG = 3'b110;
   localparam logic [2:0] SEG_KSEG3 = 3'b111;

   // smallest page, added to the shifted mask to find the odd-page select bit
   localparam logic [ADDR_W-1:0] PAGE_UNIT   = 32'h0000_1000;
   localparam logic [11:0]       OFFSET_BITS = 12'hFFF;

   // one half of an entry: valid above the frame number
   typedef struct packed {
      logic             valid;
      logic [PFN_W-1:0] pfn;
   } half_type;

   // entry tag: vpn2 above the page mask
   typedef struct packed {
      logic [VPN2_W-1:0] vpn2;
      logic [MASK_W-1:0] mask;
   } tag_type;

   // word carried down the cell chain
   typedef struct packed {
      logic                   action;
      logic [ADDR_W-1:0]      va;
      logic [ENTRY_IDX_W-1:0] entry_index;
      tag_type                tag;
      half_type               even;
      half_type               odd;
      logic                   done;
      logic [ADDR_W-1:0]      pa;
      logic [STATUS_W-1:0]    status;
      logic [ENTRY_IDX_W-1:0] hit_index;
   } word_type;

   // pack an entry-lo word into a half: valid is bit 1, frame is bits 25..6
   function automatic half_type pack_half(input logic [ADDR_W-1:0] lo);
      half_type h;
      h.valid = lo[1];
      h.pfn   = lo[25:6];
      return h;
   endfunction

endpackage

// ===== design/msat_req_if.sv =====
// request channel: valid/ready handshake with the translate or write word
interface msat_req_if;
   logic                             valid;
   logic                             ready;
   logic                             action;
   logic [msat_pkg::ADDR_W-1:0]      vaddr;
   logic [msat_pkg::ENTRY_IDX_W-1:0] entry_index;
   logic [msat_pkg::ADDR_W-1:0]      entry_lo_even;
   logic [msat_pkg::ADDR_W-1:0]      entry_lo_odd;
   logic [msat_pkg::ADDR_W-1:0]      page_size_mask;
   logic [msat_pkg::ADDR_W-1:0]      entry_tag;

   modport source (
      output valid, action, vaddr, entry_index,
      output entry_lo_even, entry_lo_odd, page_size_mask, entry_tag,
      input  ready
   );

   modport sink (
      input  valid, action, vaddr, entry_index,
      input  entry_lo_even, entry_lo_odd, page_size_mask, entry_tag,
      output ready
   );
endinterface

// ===== design/msat_rsp_if.sv =====
// response channel: valid/ready handshake with the translation result word
interface msat_rsp_if;
   logic                             valid;
   logic                             ready;
   logic [msat_pkg::ADDR_W-1:0]      physical_address;
   logic [msat_pkg::STATUS_W-1:0]    status;
   logic [msat_pkg::ENTRY_IDX_W-1:0] hit_index;

   modport source (
      output valid, physical_address, status, hit_index,
      input  ready
   );

   modport sink (
      input  valid, physical_address, status, hit_index,
      output ready
   );
endinterface

// ===== design/msat_decode.sv =====
// segment decode: resolves direct-mapped and passthrough addresses, builds the chain word
module msat_decode (
   input  logic                             user_translate,
   input  logic                             action,
   input  logic [msat_pkg::ADDR_W-1:0]      vaddr,
   input  logic [msat_pkg::ENTRY_IDX_W-1:0] entry_index,
   input  logic [msat_pkg::ADDR_W-1:0]      entry_lo_even,
   input  logic [msat_pkg::ADDR_W-1:0]      entry_lo_odd,
   input  logic [msat_pkg::ADDR_W-1:0]      page_size_mask,
   input  logic [msat_pkg::ADDR_W-1:0]      entry_tag,
   output msat_pkg::word_type               word
);
   import msat_pkg::*;

   // a tlb-bound word starts as a miss; a cell that hits overwrites it
   task automatic send_to_tlb(inout word_type w);
      w.done   = 1'b0;
      w.pa     = '0;
      w.status = STATUS_MISS;
   endtask

   always_comb begin
      word             = '0;
      word.action      = action;
      word.va          = vaddr;
      word.entry_index = entry_index;
      word.tag.vpn2    = entry_tag[31:13];
      word.tag.mask    = page_size_mask[24:13];
      word.even        = pack_half(entry_lo_even);
      word.odd         = pack_half(entry_lo_odd);
      word.hit_index   = '0;

      if (action == ACTION_WRITE) begin
         word.done   = 1'b1;
         word.pa     = '0;
         word.status = STATUS_WRITTEN;
      end else begin
         case (vaddr[31:29])
            // kseg0 and kseg1: strip the segment base
            SEG_KSEG0, SEG_KSEG1: begin
               word.done   = 1'b1;
               word.pa     = {3'b000, vaddr[28:0]};
               word.status = STATUS_DIRECT;
            end
            // kernel mapped segments always go through the tlb
            SEG_KSSEG, SEG_KSEG3: begin
               send_to_tlb(word);
            end
            // user segment
            default: begin
               if (user_translate) begin
                  send_to_tlb(word);
               end else begin
                  word.done   = 1'b1;
                  word.pa     = vaddr;
                  word.status = STATUS_DIRECT;
               end
            end
         endcase
      end
   end
endmodule

// ===== design/msat_cell.sv =====
// one tlb cell: holds an entry, matches passing words and hands them to the next cell
module msat_cell (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            advance,
   input  logic [msat_pkg::CELL_IDX_W-1:0] cell_id,
   input  logic                            prev_valid,
   input  msat_pkg::word_type              prev_word,
   output logic                            next_valid,
   output msat_pkg::word_type              next_word
);
   import msat_pkg::*;

   tag_type           tag_ff, tag_in;
   half_type          even_ff, even_in;
   half_type          odd_ff, odd_in;
   word_type          word_ff, word_in;
   logic              valid_ff, valid_in;

   logic [VPN2_W-1:0] cmp_bits;
   logic              tag_match;
   logic [ADDR_W-1:0] page_span;
   logic              odd_sel;
   half_type          sel_half;
   logic [ADDR_W-1:0] offset_mask;
   logic              entry_hit;
   logic              write_sel;

   // masked vpn2 compare and odd/even page select
   always_comb begin
      cmp_bits    = {7'h7F, ~tag_ff.mask};
      tag_match   = ((prev_word.va[31:13] ^ tag_ff.vpn2) & cmp_bits) == '0;
      page_span   = {8'd0, tag_ff.mask, 12'd0} + PAGE_UNIT;
      odd_sel     = |(prev_word.va & page_span);
      sel_half    = odd_sel ? odd_ff : even_ff;
      offset_mask = {8'd0, tag_ff.mask, OFFSET_BITS};
      entry_hit   = tag_match && sel_half.valid;
   end

   // first hit along the chain resolves the word
   always_comb begin
      word_in = prev_word;
      if (prev_word.action == ACTION_TRANSLATE && !prev_word.done && entry_hit) begin
         word_in.done      = 1'b1;
         word_in.pa        = ({sel_half.pfn, 12'd0} & ~offset_mask)
                           | (prev_word.va & offset_mask);
         word_in.status    = STATUS_HIT;
         word_in.hit_index = ENTRY_IDX_W'(cell_id);
      end
   end

   // entry load when a write word for this cell passes
   always_comb begin
      write_sel = advance && prev_valid && prev_word.action == ACTION_WRITE
                  && prev_word.entry_index == ENTRY_IDX_W'(cell_id);
      tag_in    = tag_ff;
      even_in   = even_ff;
      odd_in    = odd_ff;
      if (write_sel) begin
         tag_in  = prev_word.tag;
         even_in = prev_word.even;
         odd_in  = prev_word.odd;
      end
      valid_in = advance ? prev_valid : valid_ff;
   end

   // stored entry, cleared at reset
   always_ff @(posedge clock) begin
      if (reset) begin
         tag_ff  <= '0;
         even_ff <= '0;
         odd_ff  <= '0;
      end else begin
         tag_ff  <= tag_in;
         even_ff <= even_in;
         odd_ff  <= odd_in;
      end
   end

   // chain stage
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         word_ff <= word_in;
      end
   end

   assign next_valid = valid_ff;
   assign next_word  = word_ff;

   // a write for this cell lands in the stored tag
   a_write_lands: assert property (@(posedge clock) disable iff (reset)
      write_sel |=> tag_ff == $past(prev_word.tag))
      else $error("tlb cell did not store the written tag");

   // a resolved word never goes back to unresolved
   a_done_sticks: assert property (@(posedge clock) disable iff (reset)
      (advance && prev_valid && prev_word.done) |=> (valid_ff && word_ff.done))
      else $error("resolved word lost its done flag in a tlb cell");
endmodule

// ===== design/mips_segment_and_tlb_translate.sv =====
// top level: segment decode, chain of tlb cells and output register
//
// Usage
//   req_chan carries one word per handshake: a translate (action 0) or a tlb
//   entry write (action 1). rsp_chan returns exactly one word for each request
//   word, in request order: physical address, status and hit index.
//   csr_write_enable/csr_write_data set the user segment translate bit; write it
//   only while no request word is in flight.
// Flow
//   Each request word walks one tlb cell per cycle while the chain moves, through
//   TLB_DEPTH cells, then enters the output register that drives rsp_chan.valid.
//   Words follow one another through the cells, so one word is accepted per
//   cycle while the chain is not stalled; a write reaches its cell before any
//   later translate does, and after any earlier one.
// Reset
//   Synchronous reset clears every tlb entry (both halves invalid), empties the
//   cell chain and clears the user segment translate bit.
// Stall
//   While rsp_chan holds a word that is not taken, the whole chain freezes and
//   req_chan.ready is low; nothing is dropped.
module mips_segment_and_tlb_translate (
   input  logic       clock,
   input  logic       reset,
   msat_req_if.sink   req_chan,
   msat_rsp_if.source rsp_chan,
   input  logic       csr_write_enable,
   input  logic       csr_write_data
);
   import msat_pkg::*;

   logic     user_translate_ff, user_translate_in;
   logic     out_valid_ff, out_valid_in;
   word_type out_word_ff, out_word_in;
   logic     advance;
   word_type entry_word;

   logic     link_valid [TLB_DEPTH+1];
   word_type link_word  [TLB_DEPTH+1];

   // chain moves whenever the output register can take a word
   assign advance        = !out_valid_ff || rsp_chan.ready;
   assign req_chan.ready = advance;

   // configuration register
   always_comb begin
      user_translate_in = csr_write_enable ? csr_write_data : user_translate_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         user_translate_ff <= 1'b0;
      end else begin
         user_translate_ff <= user_translate_in;
      end
   end

   // segment decode in front of the chain
   msat_decode u_decode (
      .user_translate  (user_translate_ff),
      .action          (req_chan.action),
      .vaddr           (req_chan.vaddr),
      .entry_index     (req_chan.entry_index),
      .entry_lo_even   (req_chan.entry_lo_even),
      .entry_lo_odd    (req_chan.entry_lo_odd),
      .page_size_mask  (req_chan.page_size_mask),
      .entry_tag       (req_chan.entry_tag),
      .word            (entry_word)
   );

   assign link_valid[0] = req_chan.valid;
   assign link_word[0]  = entry_word;

   // row of tlb cells, lowest index first so the lowest match wins
   for (genvar i = 0; i < TLB_DEPTH; i++) begin : g_cell
      msat_cell u_cell (
         .clock      (clock),
         .reset      (reset),
         .advance    (advance),
         .cell_id    (CELL_IDX_W'(i)),
         .prev_valid (link_valid[i]),
         .prev_word  (link_word[i]),
         .next_valid (link_valid[i+1]),
         .next_word  (link_word[i+1])
      );
   end

   // output register
   always_comb begin
      out_valid_in = advance ? link_valid[TLB_DEPTH] : out_valid_ff;
      out_word_in  = advance ? link_word[TLB_DEPTH] : out_word_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      out_word_ff <= out_word_in;
   end

   assign rsp_chan.valid            = out_valid_ff;
   assign rsp_chan.physical_address = out_word_ff.pa;
   assign rsp_chan.status           = out_word_ff.status;
   assign rsp_chan.hit_index        = out_word_ff.hit_index;

   // misses and writes report a zero address and index
   a_zero_fields: assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && (out_word_ff.status == STATUS_MISS
                        || out_word_ff.status == STATUS_WRITTEN))
      |-> (out_word_ff.pa == '0 && out_word_ff.hit_index == '0))
      else $error("miss or write result carries a nonzero address or index");

   // status agrees with the action that produced the word
   a_status_action: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff |-> ((out_word_ff.action == ACTION_WRITE)
                        == (out_word_ff.status == STATUS_WRITTEN)))
      else $error("result status does not match its action");
endmodule
